[rtl/vsar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsar_pkg: shared types and constants for the scroll/address registers
// Event codes, nametable layout codes, the result record and address
// constants used by the update logic, the mirroring logic and the output
// buffer.
// ----------------------------------------------------------------------------
package vsar_pkg;

    // Event codes carried by each request
    typedef enum logic [2:0] {
        KIND_CTRL    = 3'd0,
        KIND_SCROLL  = 3'd1,
        KIND_ADDR    = 3'd2,
        KIND_ACCESS  = 3'd3,
        KIND_COARSE  = 3'd4,
        KIND_VERT    = 3'd5,
        KIND_COPY_H  = 3'd6,
        KIND_COPY_V  = 3'd7
    } t_kind;

    // Nametable layout codes
    typedef enum logic [1:0] {
        MIRR_ONE_LOW  = 2'd0,
        MIRR_ONE_HIGH = 2'd1,
        MIRR_HORIZ    = 2'd2,
        MIRR_VERT     = 2'd3
    } t_mirror;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned TEMP_W = 15;
    localparam int unsigned FINE_W = 3;

    // Address map constants
    localparam logic [3:0]        NT_REGION_HI  = 4'h2;   // 0x2000..0x2FFF
    localparam logic [5:0]        NT_LOW_BASE   = 6'b001000; // 0x2000 >> 10
    localparam logic [5:0]        NT_HIGH_BASE  = 6'b001001; // 0x2400 >> 10
    localparam logic [ADDR_W-1:0] PAL_LIMIT     = 16'h3F20;
    localparam logic [ADDR_W-1:0] PAL_BASE      = 16'h3F00;
    localparam logic [ADDR_W-1:0] PAL_BG_ALIAS  = 16'h3F10;

    // Pointer field constants
    localparam logic [4:0] COARSE_MAX = 5'd31;
    localparam logic [4:0] ROW_WRAP   = 5'd29;
    localparam logic [4:0] ROW_MAX    = 5'd31;
    localparam logic [2:0] FINE_Y_MAX = 3'd7;

    // One result record
    typedef struct packed {
        logic [ADDR_W-1:0] access_address;
        logic [ADDR_W-1:0] video_pointer;
        logic [TEMP_W-1:0] temp_pointer;
        logic [FINE_W-1:0] fine_scroll_x;
        logic              second_write;
    } t_result;

endpackage

[rtl/vsar_mirror.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsar_mirror: video memory address mirroring
// Folds nametable addresses by the selected layout and folds the palette
// area onto its 32-byte window, with the background color alias.
// ----------------------------------------------------------------------------
module vsar_mirror
    import vsar_pkg::*;
(
    input  logic [1:0]        i_mode,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [ADDR_W-1:0] o_addr
);

    logic [ADDR_W-1:0] nt_addr;

    // Nametable folding, only inside 0x2000..0x2FFF
    always_comb begin
        nt_addr = i_addr;
        if (i_addr[15:12] == NT_REGION_HI) begin
            unique case (t_mirror'(i_mode))
                MIRR_ONE_LOW:  nt_addr = {NT_LOW_BASE, i_addr[9:0]};
                MIRR_ONE_HIGH: nt_addr = {NT_HIGH_BASE, i_addr[9:0]};
                MIRR_HORIZ:    nt_addr = {i_addr[15:11], 1'b0, i_addr[9:0]};
                MIRR_VERT:     nt_addr = {i_addr[15:12], 1'b0, i_addr[10:0]};
            endcase
        end
    end

    // Palette window, then the background alias
    always_comb begin
        o_addr = nt_addr;
        if (i_addr >= PAL_LIMIT) begin
            o_addr = PAL_BASE | {11'd0, i_addr[4:0]};
        end
        if (o_addr == PAL_BG_ALIAS) begin
            o_addr = PAL_BASE;
        end
    end

endmodule

[rtl/vsar_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsar_regs: scroll and address state with its per-event update
// Holds the video pointer, temporary pointer, fine X, write toggle and
// increment flag; applies one event per accepted request and forms the
// result record from the updated state and the pre-update access address.
// ----------------------------------------------------------------------------
module vsar_regs
    import vsar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_rendering,
    input  logic [1:0]  i_mode,
    output t_result     o_result
);

    logic [ADDR_W-1:0] r_video, n_video;
    logic [TEMP_W-1:0] r_temp, n_temp;
    logic [FINE_W-1:0] r_fine, n_fine;
    logic              r_toggle, n_toggle;
    logic              r_step_row, n_step_row;
    logic [ADDR_W-1:0] mirrored;
    logic [ADDR_W-1:0] access;

    // Coarse X increment: wrap at 31 and switch horizontal nametable
    function automatic logic [ADDR_W-1:0] coarse_step(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        if (v[4:0] == COARSE_MAX) begin
            r = {v[15:11], ~v[10], v[9:5], 5'd0};
        end else begin
            r = {v[15:5], v[4:0] + 5'd1};
        end
        return r;
    endfunction

    // Vertical increment: fine Y, then coarse Y with the row-29 wrap
    function automatic logic [ADDR_W-1:0] vert_step(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        if (v[14:12] != FINE_Y_MAX) begin
            r = {v[15], v[14:12] + 3'd1, v[11:0]};
        end else if (v[9:5] == ROW_WRAP) begin
            r = {v[15], 3'd0, ~v[11], v[10], 5'd0, v[4:0]};
        end else if (v[9:5] == ROW_MAX) begin
            r = {v[15], 3'd0, v[11:10], 5'd0, v[4:0]};
        end else begin
            r = {v[15], 3'd0, v[11:10], v[9:5] + 5'd1, v[4:0]};
        end
        return r;
    endfunction

    vsar_mirror u_mirror (
        .i_mode (i_mode),
        .i_addr (r_video),
        .o_addr (mirrored)
    );

    // Event decode and next state
    always_comb begin
        n_video    = r_video;
        n_temp     = r_temp;
        n_fine     = r_fine;
        n_toggle   = r_toggle;
        n_step_row = r_step_row;
        access     = '0;
        unique case (t_kind'(i_kind))
            KIND_CTRL: begin
                n_temp[11:10] = i_data_byte[1:0];
                n_step_row    = i_data_byte[2];
            end
            KIND_SCROLL: begin
                if (!r_toggle) begin
                    n_temp[4:0] = i_data_byte[7:3];
                    n_fine      = i_data_byte[2:0];
                end else begin
                    n_temp[9:5]   = i_data_byte[7:3];
                    n_temp[14:12] = i_data_byte[2:0];
                end
                n_toggle = ~r_toggle;
            end
            KIND_ADDR: begin
                if (!r_toggle) begin
                    n_temp[13:8] = i_data_byte[5:0];
                    n_temp[14]   = 1'b0;
                end else begin
                    n_temp[7:0] = i_data_byte;
                    n_video     = {1'b0, r_temp[14:8], i_data_byte};
                end
                n_toggle = ~r_toggle;
            end
            KIND_ACCESS: begin
                access = mirrored;
                if (!i_rendering) begin
                    n_video = r_video + (r_step_row ? 16'd32 : 16'd1);
                end else begin
                    n_video = vert_step(coarse_step(r_video));
                end
            end
            KIND_COARSE: n_video = coarse_step(r_video);
            KIND_VERT:   n_video = vert_step(r_video);
            KIND_COPY_H: begin
                n_video = {r_video[15:11], r_temp[10], r_video[9:5], r_temp[4:0]};
            end
            KIND_COPY_V: begin
                n_video = {1'b0, r_temp[14:11], r_video[10], r_temp[9:5], r_video[4:0]};
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video    <= '0;
            r_temp     <= '0;
            r_fine     <= '0;
            r_toggle   <= 1'b0;
            r_step_row <= 1'b0;
        end else if (i_accept) begin
            r_video    <= n_video;
            r_temp     <= n_temp;
            r_fine     <= n_fine;
            r_toggle   <= n_toggle;
            r_step_row <= n_step_row;
        end
    end

    assign o_result = '{
        access_address: access,
        video_pointer:  n_video,
        temp_pointer:   n_temp,
        fine_scroll_x:  n_fine,
        second_write:   n_toggle
    };

endmodule

[rtl/vsar_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsar_out_buf: result register with skid entry
// Output register plus one skid entry; upstream stall comes from a flop,
// so a request is taken while a finished result still waits downstream.
// ----------------------------------------------------------------------------
module vsar_out_buf
    import vsar_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/video_scroll_address_registers.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_scroll_address_registers: picture unit scroll/address registers
// Top level: input handshake, mirroring register, state update and
// buffered result channel.
// ----------------------------------------------------------------------------
// Takes one event request per clock while o_in_stall is low and returns
// exactly one result per request, registered in the output register or, if
// that is stalled, in the skid entry. The whole event (register write, data
// access with address mirroring, or render-time pointer update) is applied
// at acceptance by the state update logic, so throughput is one request per
// cycle. The result channel has an output register plus one skid entry;
// o_in_stall rises only when both hold results that the downstream side has
// not yet taken. The mirroring register is written through i_cfg_wr_en /
// i_cfg_wr_data and should be changed only while no request is in flight.
// ----------------------------------------------------------------------------
module video_scroll_address_registers
    import vsar_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_wr_data,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_kind,
    input  logic [7:0]        i_data_byte,
    input  logic              i_rendering,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ADDR_W-1:0] o_access_address,
    output logic [ADDR_W-1:0] o_video_pointer,
    output logic [TEMP_W-1:0] o_temp_pointer,
    output logic [FINE_W-1:0] o_fine_scroll_x,
    output logic              o_second_write
);

    logic [1:0] r_mode;
    logic       accept;
    logic       buf_full;
    t_result    step_result;
    t_result    out_result;

    // Mirroring mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MIRR_ONE_LOW;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    vsar_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_rendering (i_rendering),
        .i_mode      (r_mode),
        .o_result    (step_result)
    );

    vsar_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_access_address = out_result.access_address;
    assign o_video_pointer  = out_result.video_pointer;
    assign o_temp_pointer   = out_result.temp_pointer;
    assign o_fine_scroll_x  = out_result.fine_scroll_x;
    assign o_second_write   = out_result.second_write;

endmodule
